[rtl/core/jdisp_pkg.sv]
// shared types and constants of the job dispatcher
package jdisp_pkg;

  localparam int MAX_SERVERS = 8;
  localparam int SRV_W = 3;
  localparam int SCNT_W = 4;

  localparam logic [SCNT_W-1:0] SERVERS_RESET = 4'd8;
  localparam logic [SCNT_W-1:0] SERVERS_MIN = 4'd1;
  localparam logic [SCNT_W-1:0] SERVERS_MAX = 4'd8;

  typedef logic [SRV_W-1:0] srv_id_t;
  typedef logic [SCNT_W-1:0] srv_cnt_t;

  typedef enum logic {
    REQ_ARRIVAL = 1'b0,
    REQ_RELEASE = 1'b1
  } req_type_t;

  function automatic srv_cnt_t clamp_servers(input srv_cnt_t v);
    srv_cnt_t r;
    if (v < SERVERS_MIN) begin
      r = SERVERS_MIN;
    end else if (v > SERVERS_MAX) begin
      r = SERVERS_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[rtl/core/jdisp_ram.sv]
// generic single-port-write ram with registered read
module jdisp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/multi_server_job_dispatcher.sv]
// job dispatcher top level: free-server stack, busy table and fifo wait queue
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | req_type, job_id, server_id
//  out_    | output    | out_valid/out_stall | done, start, enqueued, dropped, bad_release
//  cfg_    | input     | cfg_we              | cfg_wdata (servers in use)
//
// each transfer takes a read step, which reads the busy-job and wait-queue memories,
// then an update step, which updates state, writes back and loads the output register.
// in_stall is high during the update step; a new transfer can be taken while
// a result waits in the output register, but the update step waits until it leaves.
// a servers-in-use write re-initializes the free stack, busy flags and wait queue at once.
module multi_server_job_dispatcher #(
  parameter int QUEUE_DEPTH = 64,
  parameter int JOB_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [JOB_BITS-1:0] in_job_id,
  input  logic [2:0]          in_server_id,

  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_done_valid,
  output logic [JOB_BITS-1:0] out_done_job,
  output logic                out_start_valid,
  output logic [2:0]          out_start_server,
  output logic [JOB_BITS-1:0] out_start_job,
  output logic                out_enqueued,
  output logic                out_dropped,
  output logic                out_bad_release,

  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int NSRV = jdisp_pkg::MAX_SERVERS;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QUEUE_DEPTH);
  localparam jdisp_pkg::srv_cnt_t SCNT_FULL = jdisp_pkg::srv_cnt_t'(NSRV);

  // control state
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  jdisp_pkg::srv_cnt_t   srv_use_r, srv_use_nxt;
  jdisp_pkg::srv_cnt_t   free_cnt_r, free_cnt_nxt;
  logic [NSRV-1:0]       stk_vld_r, stk_vld_nxt;
  logic [NSRV-1:0]       busy_flag_r, busy_flag_nxt;
  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [PTR_W-1:0]      tail_r, tail_nxt;
  logic [QCNT_W-1:0]     qcnt_r, qcnt_nxt;

  // payload
  jdisp_pkg::srv_id_t    stk_r [NSRV];
  logic                  s1_req_r;
  logic [JOB_BITS-1:0]   s1_job_r;
  jdisp_pkg::srv_id_t    s1_sid_r;

  logic                  res_done_valid, res_start_valid, res_enq, res_drop, res_bad;
  logic [JOB_BITS-1:0]   res_done_job, res_start_job;
  jdisp_pkg::srv_id_t    res_start_srv;
  logic                  done_valid_r, start_valid_r, enq_r, drop_r, bad_r;
  logic [JOB_BITS-1:0]   done_job_r, start_job_r;
  jdisp_pkg::srv_id_t    start_srv_r;

  logic                  in_xfer, s1_done;
  logic                  push_en;
  jdisp_pkg::srv_id_t    push_idx, pop_idx, pop_srv;
  jdisp_pkg::srv_cnt_t   cnt_dec, reinit_val;

  logic                  bj_we;
  jdisp_pkg::srv_id_t    bj_waddr;
  logic [JOB_BITS-1:0]   bj_wdata, bj_rdata;
  logic                  q_we;
  logic [JOB_BITS-1:0]   q_rdata;

  assign in_stall = s1_valid_r;
  assign in_xfer = in_valid && !in_stall;
  assign s1_done = s1_valid_r && (!out_valid_r || !out_stall);

  jdisp_ram #(
    .WIDTH(JOB_BITS),
    .DEPTH(NSRV)
  ) u_busy_ram (
    .clk   (clk),
    .we    (bj_we),
    .waddr (bj_waddr),
    .wdata (bj_wdata),
    .re    (in_xfer),
    .raddr (in_server_id),
    .rdata (bj_rdata)
  );

  jdisp_ram #(
    .WIDTH(JOB_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_r),
    .wdata (s1_job_r),
    .re    (in_xfer),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  // top of free stack; an entry not yet pushed holds its re-init value
  always_comb begin
    cnt_dec = free_cnt_r - jdisp_pkg::srv_cnt_t'(1);
    pop_idx = cnt_dec[jdisp_pkg::SRV_W-1:0];
    reinit_val = srv_use_r - jdisp_pkg::srv_cnt_t'(1) - {1'b0, pop_idx};
    pop_srv = stk_vld_r[pop_idx] ? stk_r[pop_idx] : reinit_val[jdisp_pkg::SRV_W-1:0];
    push_idx = free_cnt_r[jdisp_pkg::SRV_W-1:0];
  end

  // update step: decide, update and write back
  always_comb begin
    free_cnt_nxt = free_cnt_r;
    stk_vld_nxt = stk_vld_r;
    busy_flag_nxt = busy_flag_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    qcnt_nxt = qcnt_r;
    push_en = 1'b0;
    bj_we = 1'b0;
    bj_waddr = s1_sid_r;
    bj_wdata = s1_job_r;
    q_we = 1'b0;
    res_done_valid = 1'b0;
    res_done_job = '0;
    res_start_valid = 1'b0;
    res_start_srv = '0;
    res_start_job = '0;
    res_enq = 1'b0;
    res_drop = 1'b0;
    res_bad = 1'b0;
    if (s1_req_r == jdisp_pkg::REQ_ARRIVAL) begin
      if (free_cnt_r != '0) begin
        free_cnt_nxt = cnt_dec;
        busy_flag_nxt[pop_srv] = 1'b1;
        bj_we = s1_done;
        bj_waddr = pop_srv;
        res_start_valid = 1'b1;
        res_start_srv = pop_srv;
        res_start_job = s1_job_r;
      end else if (qcnt_r < QCNT_FULL) begin
        q_we = s1_done;
        tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
        qcnt_nxt = qcnt_r + QCNT_W'(1);
        res_enq = 1'b1;
      end else begin
        res_drop = 1'b1;
      end
    end else begin
      if ({1'b0, s1_sid_r} >= srv_use_r || !busy_flag_r[s1_sid_r]) begin
        res_bad = 1'b1;
      end else begin
        res_done_valid = 1'b1;
        res_done_job = bj_rdata;
        if (qcnt_r != '0) begin
          head_nxt = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
          qcnt_nxt = qcnt_r - QCNT_W'(1);
          bj_we = s1_done;
          bj_wdata = q_rdata;
          res_start_valid = 1'b1;
          res_start_srv = s1_sid_r;
          res_start_job = q_rdata;
        end else begin
          busy_flag_nxt[s1_sid_r] = 1'b0;
          if (free_cnt_r < SCNT_FULL) begin
            push_en = s1_done;
            stk_vld_nxt[push_idx] = 1'b1;
            free_cnt_nxt = free_cnt_r + jdisp_pkg::srv_cnt_t'(1);
          end
        end
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_done) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_done) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    srv_use_nxt = cfg_we ? jdisp_pkg::clamp_servers(cfg_wdata) : srv_use_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      srv_use_r <= jdisp_pkg::SERVERS_RESET;
      free_cnt_r <= jdisp_pkg::SERVERS_RESET;
      stk_vld_r <= '0;
      busy_flag_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      qcnt_r <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      srv_use_r <= srv_use_nxt;
      if (cfg_we) begin
        free_cnt_r <= srv_use_nxt;
        stk_vld_r <= '0;
        busy_flag_r <= '0;
        head_r <= '0;
        tail_r <= '0;
        qcnt_r <= '0;
      end else if (s1_done) begin
        free_cnt_r <= free_cnt_nxt;
        stk_vld_r <= stk_vld_nxt;
        busy_flag_r <= busy_flag_nxt;
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        qcnt_r <= qcnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_req_r <= in_req_type;
      s1_job_r <= in_job_id;
      s1_sid_r <= in_server_id;
    end
    if (push_en) begin
      stk_r[push_idx] <= s1_sid_r;
    end
    if (s1_done) begin
      done_valid_r <= res_done_valid;
      done_job_r <= res_done_job;
      start_valid_r <= res_start_valid;
      start_srv_r <= res_start_srv;
      start_job_r <= res_start_job;
      enq_r <= res_enq;
      drop_r <= res_drop;
      bad_r <= res_bad;
    end
  end

  assign out_valid = out_valid_r;
  assign out_done_valid = done_valid_r;
  assign out_done_job = done_job_r;
  assign out_start_valid = start_valid_r;
  assign out_start_server = start_srv_r;
  assign out_start_job = start_job_r;
  assign out_enqueued = enq_r;
  assign out_dropped = drop_r;
  assign out_bad_release = bad_r;

  a_qcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= QCNT_FULL)
    else $error("wait queue count out of range");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= srv_use_r)
    else $error("free server count above servers in use");

  a_xfer_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted transfer lost before second cycle");

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot({enq_r, drop_r, bad_r, done_valid_r,
                             start_valid_r && !done_valid_r}))
    else $error("result carries no or conflicting outcome");

endmodule
